// File: rtl/core/chained_hash_record_table_defines.svh
// Assertion macros for the chained hash record table.
// No dependencies.
`ifndef CHAINED_HASH_RECORD_TABLE_DEFINES_SVH
`define CHAINED_HASH_RECORD_TABLE_DEFINES_SVH

// Implication checked every clock outside reset.
`define CHRT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Invariant checked every clock outside reset.
`define CHRT_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// File: rtl/core/chrt_pkg.sv
// Package for the chained hash record table: sizes, status codes, FSM states.
// No dependencies.
package chrt_pkg;
    localparam int SLOTS     = 16;
    localparam int KEY_BYTES = 8;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int LINK_W    = SLOT_W + 1;
    localparam int CAP_W     = 5;
    localparam int KEY_W     = 64;
    localparam int BUCKET_W  = 4;
    localparam int STATUS_W  = 3;
    localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
    localparam logic [KEY_W-1:0] KEY_MASK = ~({KEY_W{1'b1}} >> (8 * KEY_BYTES - 1) >> 1);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_NOT_FOUND  = 3'd1,
        ST_FULL       = 3'd2,
        ST_DUPLICATE  = 3'd3,
        ST_BAD_BUCKET = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HEAD,
        S_WALK,
        S_LINK,
        S_DONE
    } state_t;

    localparam logic ACT_FIND   = 1'b0;
    localparam logic ACT_INSERT = 1'b1;
endpackage

// File: rtl/core/chrt_if.sv
// Valid/ready channel interfaces for the chained hash record table.
// Depends on chrt_pkg.
interface chrt_req_if import chrt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                action;
    logic [KEY_W-1:0]    key;
    logic [BUCKET_W-1:0] bucket;
    modport source (output valid, action, key, bucket, input ready);
    modport sink   (input valid, action, key, bucket, output ready);
endinterface

interface chrt_rsp_if import chrt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    modport source (output valid, status, slot, input ready);
    modport sink   (input valid, status, slot, output ready);
endinterface

interface chrt_cfg_if import chrt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: rtl/core/chrt_chain_mem.sv
// Slot memory: key store and chain-next links, one synchronous write port and one synchronous read port.
// Depends on chrt_pkg.
module chrt_chain_mem import chrt_pkg::*; (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_addr,
    input  logic [KEY_W-1:0]  wr_key,
    input  logic [LINK_W-1:0] wr_next,
    input  logic [SLOT_W-1:0] rd_addr,
    output logic [KEY_W-1:0]  rd_key,
    output logic [LINK_W-1:0] rd_next
);
    logic [KEY_W-1:0]  key_mem  [SLOTS];
    logic [LINK_W-1:0] next_mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]  <= wr_key;
            next_mem[wr_addr] <= wr_next;
        end
        rd_key  <= key_mem[rd_addr];
        rd_next <= next_mem[rd_addr];
    end
endmodule

// File: rtl/core/chained_hash_record_table.sv
// Chained hash record table. A request word (find or insert of a 64-bit key
// in a given bucket) gives its result word after the head, walk, link and done
// states in turn: walk once per slot visited in the bucket chain, link only for
// an insert that finds no duplicate (a bad bucket or empty chain skips the walk). The walk
// reads one slot per cycle from the slot memory and visits at most capacity
// slots. Inserts use slots in order 0,1,2..., since slots are never freed; a
// full table answers table full. A capacity write is taken only while idle and
// clears all chains (head registers, allocation count); there is no clearing
// pass after reset. The result word is held in an output register; the next
// request is accepted no earlier than the cycle after that word is taken.
// Depends on chrt_pkg, chrt_if, chrt_chain_mem and the defines header.
`include "chained_hash_record_table_defines.svh"
module chained_hash_record_table import chrt_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    chrt_cfg_if.sink    cfg,
    chrt_req_if.sink    req,
    chrt_rsp_if.source  rsp
);
    // Bucket head links and the allocation counter (next idle slot).
    logic [LINK_W-1:0]   head_reg [SLOTS];
    logic [CAP_W-1:0]    cap_reg, cap_next;
    logic [LINK_W-1:0]   alloc_reg, alloc_next;
    state_t              state_reg, state_next;
    logic                act_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [BUCKET_W-1:0] bkt_reg;
    logic [CAP_W-1:0]    cnt_reg, cnt_next;
    logic                rsp_valid_reg;
    status_t             rsp_status_reg, status_next;
    logic [SLOT_W-1:0]   rsp_slot_reg, slot_next;

    logic              mem_wr;
    logic [SLOT_W-1:0] mem_rd_addr;
    logic [KEY_W-1:0]  mem_rd_key;
    logic [LINK_W-1:0] mem_rd_next;
    logic              hit;
    logic              accept;
    logic [CAP_W-1:0]  cfg_clamped;

    chrt_chain_mem u_mem (
        .clk     (clk),
        .wr_en   (mem_wr),
        .wr_addr (alloc_reg[SLOT_W-1:0]),
        .wr_key  (key_reg),
        .wr_next (head_reg[bkt_reg]),
        .rd_addr (mem_rd_addr),
        .rd_key  (mem_rd_key),
        .rd_next (mem_rd_next)
    );

    assign cfg.ready = (state_reg == S_IDLE);
    assign req.ready = (state_reg == S_IDLE) && !rsp_valid_reg && !cfg.valid;
    assign accept    = req.valid && req.ready;
    assign rsp.valid  = rsp_valid_reg;
    assign rsp.status = rsp_status_reg;
    assign rsp.slot   = rsp_slot_reg;

    always_comb
    begin
        if (cfg.data < CAP_W'(2))
            cfg_clamped = CAP_W'(2);
        else if (cfg.data > CAP_W'(SLOTS))
            cfg_clamped = CAP_W'(SLOTS);
        else
            cfg_clamped = cfg.data;
    end

    assign hit      = ((mem_rd_key ^ key_reg) & KEY_MASK) == '0;
    assign mem_rd_addr = (state_reg == S_HEAD) ? head_reg[bkt_reg][SLOT_W-1:0]
                                               : mem_rd_next[SLOT_W-1:0];
    // Write only when a slot is really taken; a full table leaves memory alone.
    assign mem_wr   = (state_reg == S_LINK) && (alloc_reg < LINK_W'(cap_reg));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: state_next = S_IDLE;
            S_IDLE:  if (accept) state_next = S_HEAD;
            S_HEAD:
            begin
                if ({1'b0, bkt_reg} >= cap_reg)
                    state_next = S_DONE;
                else if (head_reg[bkt_reg] >= LINK_W'(cap_reg))
                    state_next = (act_reg == ACT_INSERT) ? S_LINK : S_DONE;
                else
                    state_next = S_WALK;
            end
            S_WALK:
            begin
                if (hit || !(cnt_reg + CAP_W'(1) < cap_reg)
                        || !(mem_rd_next < LINK_W'(cap_reg)))
                    state_next = (!hit && act_reg == ACT_INSERT) ? S_LINK : S_DONE;
            end
            S_LINK:  state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and result.
    always_comb
    begin
        cnt_next    = cnt_reg;
        alloc_next  = alloc_reg;
        cap_next    = cap_reg;
        status_next = rsp_status_reg;
        slot_next   = rsp_slot_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg.valid)
                begin
                    cap_next   = cfg_clamped;
                    alloc_next = '0;
                end
            end
            S_HEAD:
            begin
                cnt_next  = '0;
                slot_next = '0;
                if ({1'b0, bkt_reg} >= cap_reg)
                    status_next = ST_BAD_BUCKET;
                else
                    status_next = ST_NOT_FOUND;
            end
            S_WALK:
            begin
                cnt_next = cnt_reg + CAP_W'(1);
                if (hit)
                    status_next = (act_reg == ACT_INSERT) ? ST_DUPLICATE : ST_OK;
            end
            S_LINK:
            begin
                if (alloc_reg >= LINK_W'(cap_reg))
                    status_next = ST_FULL;
                else
                begin
                    status_next = ST_OK;
                    slot_next   = alloc_reg[SLOT_W-1:0];
                    alloc_next  = alloc_reg + LINK_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cap_reg       <= CAP_RESET;
            alloc_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
                head_reg[i] <= NIL;
        end
        else
        begin
            state_reg <= state_next;
            cap_reg   <= cap_next;
            alloc_reg <= alloc_next;
            if (rsp_valid_reg && rsp.ready)
                rsp_valid_reg <= 1'b0;
            else if (state_reg == S_DONE)
                rsp_valid_reg <= 1'b1;
            if (state_reg == S_IDLE && cfg.valid)
                for (int i = 0; i < SLOTS; i++)
                    head_reg[i] <= NIL;
            if (state_reg == S_LINK && alloc_reg < LINK_W'(cap_reg))
                head_reg[bkt_reg] <= alloc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= req.action;
            key_reg <= req.key & KEY_MASK;
            bkt_reg <= req.bucket;
        end
        cnt_reg        <= cnt_next;
        rsp_status_reg <= status_next;
        rsp_slot_reg   <= slot_next;
    end

    `CHRT_ASSERT_ALWAYS(a_alloc_bound, clk, rst_n, alloc_reg <= LINK_W'(cap_reg),
        "allocation past capacity")
    `CHRT_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, !req.ready,
        "request taken while busy")
    `CHRT_ASSERT_IMPL(a_link_slot, clk, rst_n,
        state_reg == S_DONE && rsp_status_reg == ST_OK && act_reg == ACT_INSERT
            && !$past(state_reg == S_WALK),
        rsp_slot_reg == alloc_reg[SLOT_W-1:0] - SLOT_W'(1),
        "inserted slot does not match allocation")
endmodule
